### src/aat_pkg.sv
// Shared constants, register indexes and pipeline control type for the box transform.
`default_nettype none
package aat_pkg;

    // Coefficient and configuration register geometry
    localparam int CoefWidth   = 32;
    localparam int CfgWidth    = 64;
    localparam int CfgIdxWidth = 3;
    localparam int NumAxes     = 3;

    // Default field format: signed Q16.16
    localparam int DefCoordWidth = 32;
    localparam int DefFracBits   = 16;

    // Pipeline depth: multiply, min/max, partial add, final add, saturate
    localparam int PipeStages = 5;
    localparam int LastStage  = PipeStages - 1;

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] RegRowXLo = 3'd0;
    localparam logic [CfgIdxWidth-1:0] RegRowXHi = 3'd1;
    localparam logic [CfgIdxWidth-1:0] RegRowYLo = 3'd2;
    localparam logic [CfgIdxWidth-1:0] RegRowYHi = 3'd3;
    localparam logic [CfgIdxWidth-1:0] RegRowZLo = 3'd4;
    localparam logic [CfgIdxWidth-1:0] RegRowZHi = 3'd5;

    // Reset values: identity transform in Q16.16
    localparam logic [CfgWidth-1:0] RstRowXLo = 64'h0001_0000_0000_0000;
    localparam logic [CfgWidth-1:0] RstRowXHi = 64'h0000_0000_0000_0000;
    localparam logic [CfgWidth-1:0] RstRowYLo = 64'h0000_0000_0001_0000;
    localparam logic [CfgWidth-1:0] RstRowYHi = 64'h0000_0000_0000_0000;
    localparam logic [CfgWidth-1:0] RstRowZLo = 64'h0000_0000_0000_0000;
    localparam logic [CfgWidth-1:0] RstRowZHi = 64'h0001_0000_0000_0000;

    // Per-stage load enables and valid bits
    typedef struct packed {
        logic [PipeStages-1:0] en;
        logic [PipeStages-1:0] v;
    } t_pipe_ctl;

endpackage
`default_nettype wire

### src/aat_pipe_ctrl.sv
// Valid bits and per-stage load enables of the transform pipeline.
`default_nettype none
module aat_pipe_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_out_ready,
    output aat_pkg::t_pipe_ctl  o_ctl
);
    import aat_pkg::*;

    logic [PipeStages-1:0] r_v;
    logic [PipeStages-1:0] n_v;
    logic [PipeStages-1:0] w_en;

    // A stage loads when it is empty or its content moves on
    always_comb begin
        w_en[LastStage] = !r_v[LastStage] || i_out_ready;
        for (int k = LastStage - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    // Valid bits follow their data
    always_comb begin
        n_v[0] = w_en[0] ? i_in_valid : r_v[0];
        for (int k = 1; k < PipeStages; k++) begin
            n_v[k] = w_en[k] ? r_v[k-1] : r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_ctl.en = w_en;
    assign o_ctl.v  = r_v;

    // Items in flight change only by transfers in and out
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (int'($countones(r_v)) == int'($countones($past(r_v)))
                + int'($past(i_in_valid && w_en[0]))
                - int'($past(r_v[LastStage] && i_out_ready))))
        else $error("pipeline item count mismatch");

    // A full pipeline with a stalled output takes nothing in
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v && !i_out_ready) |-> !w_en[0])
        else $error("input accepted while pipeline full and stalled");

    // A stalled result stays in place
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[LastStage] && !i_out_ready) |=> r_v[LastStage])
        else $error("stalled result lost");

endmodule
`default_nettype wire

### src/aat_row.sv
// Datapath for one output axis: products, corner min/max, sums and saturation.
`default_nettype none
module aat_row #(
    parameter int COORD_WIDTH = aat_pkg::DefCoordWidth,
    parameter int FRAC_BITS   = aat_pkg::DefFracBits
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  aat_pkg::t_pipe_ctl                    i_ctl,
    input  wire        [aat_pkg::CfgWidth-1:0]    i_cfg_lo,
    input  wire        [aat_pkg::CfgWidth-1:0]    i_cfg_hi,
    input  wire signed [COORD_WIDTH-1:0]          i_lo [aat_pkg::NumAxes],
    input  wire signed [COORD_WIDTH-1:0]          i_hi [aat_pkg::NumAxes],
    output logic signed [COORD_WIDTH-1:0]         o_min,
    output logic signed [COORD_WIDTH-1:0]         o_max
);
    import aat_pkg::*;

    localparam int PW = CoefWidth + COORD_WIDTH;
    localparam int TW = CoefWidth + FRAC_BITS + 1;
    localparam int SW = ((PW > TW) ? PW : TW) + 2;
    localparam logic signed [COORD_WIDTH-1:0] MaxV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] MinV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [CoefWidth-1:0] w_coef [NumAxes];
    logic signed [CoefWidth-1:0] w_trans;
    logic signed [SW-1:0]        w_tsh;

    logic signed [PW-1:0] r_p_lo [NumAxes];
    logic signed [PW-1:0] r_p_hi [NumAxes];
    logic signed [PW-1:0] r_mn   [NumAxes];
    logic signed [PW-1:0] r_mx   [NumAxes];
    logic signed [SW-1:0] r_a_mn, r_b_mn, r_a_mx, r_b_mx;
    logic signed [SW-1:0] r_sum_mn, r_sum_mx;
    logic signed [COORD_WIDTH-1:0] r_out_mn, r_out_mx;
    logic signed [COORD_WIDTH-1:0] n_out_mn, n_out_mx;

    // Floor by the fraction bits, then clamp to the coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0]      sh;
        logic [SW-COORD_WIDTH:0]   top;
        sh  = v >>> FRAC_BITS;
        top = sh[SW-1:COORD_WIDTH-1];
        if ((&top) || !(|top)) begin
            return sh[COORD_WIDTH-1:0];
        end else if (sh[SW-1]) begin
            return MinV;
        end else begin
            return MaxV;
        end
    endfunction

    // Coefficient unpacking
    assign w_coef[0] = i_cfg_lo[CfgWidth-1:CoefWidth];
    assign w_coef[1] = i_cfg_lo[CoefWidth-1:0];
    assign w_coef[2] = i_cfg_hi[CfgWidth-1:CoefWidth];
    assign w_trans   = i_cfg_hi[CoefWidth-1:0];
    assign w_tsh     = SW'(w_trans) <<< FRAC_BITS;

    // Stage 1: both corner products per column
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            for (int j = 0; j < NumAxes; j++) begin
                r_p_lo[j] <= PW'(w_coef[j]) * PW'(i_lo[j]);
                r_p_hi[j] <= PW'(w_coef[j]) * PW'(i_hi[j]);
            end
        end
    end

    // Stage 2: least and greatest term per column
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            for (int j = 0; j < NumAxes; j++) begin
                r_mn[j] <= (r_p_lo[j] < r_p_hi[j]) ? r_p_lo[j] : r_p_hi[j];
                r_mx[j] <= (r_p_lo[j] < r_p_hi[j]) ? r_p_hi[j] : r_p_lo[j];
            end
        end
    end

    // Stage 3: partial sums, translation joins here
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_a_mn <= SW'(r_mn[0]) + SW'(r_mn[1]);
            r_b_mn <= SW'(r_mn[2]) + w_tsh;
            r_a_mx <= SW'(r_mx[0]) + SW'(r_mx[1]);
            r_b_mx <= SW'(r_mx[2]) + w_tsh;
        end
    end

    // Stage 4: full-precision sums
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_sum_mn <= r_a_mn + r_b_mn;
            r_sum_mx <= r_a_mx + r_b_mx;
        end
    end

    // Stage 5: truncate and saturate into the output register
    assign n_out_mn = sat(r_sum_mn);
    assign n_out_mx = sat(r_sum_mx);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_out_mn <= n_out_mn;
            r_out_mx <= n_out_mx;
        end
    end

    assign o_min = r_out_mn;
    assign o_max = r_out_mx;

    // Monotone rounding keeps the box ordered
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.v[LastStage] |-> (o_min <= o_max))
        else $error("transformed box minimum above maximum");

endmodule
`default_nettype wire

### src/aabb_affine_transform.sv
// Throughput: one box per cycle; the five-stage pipeline takes an item every cycle unless
// it is full and the output is stalled, and a stall only holds the stages that are full.
// Each output axis is min/max of per-column corner products plus translation.
// Reset (synchronous, active low) empties the pipeline and loads the identity matrix.
// Top level of the bounding-box affine transform.
`default_nettype none
module aabb_affine_transform #(
    parameter int COORD_WIDTH = aat_pkg::DefCoordWidth,
    parameter int FRAC_BITS   = aat_pkg::DefFracBits
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // Box input
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z from bit 0 up, zero padded to bytes
    input  wire  [((6*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // Box output
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z from bit 0 up, zero padded to bytes
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // Configuration writes
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [aat_pkg::CfgIdxWidth-1:0]    i_cfg_index,
    input  wire  [aat_pkg::CfgWidth-1:0]       i_cfg_data
);
    import aat_pkg::*;

    localparam int DW = ((6*COORD_WIDTH+7)/8)*8;

    t_pipe_ctl w_ctl;

    logic [CfgWidth-1:0] r_row_x_lo, r_row_x_hi;
    logic [CfgWidth-1:0] r_row_y_lo, r_row_y_hi;
    logic [CfgWidth-1:0] r_row_z_lo, r_row_z_hi;

    logic signed [COORD_WIDTH-1:0] w_lo [NumAxes];
    logic signed [COORD_WIDTH-1:0] w_hi [NumAxes];
    logic signed [COORD_WIDTH-1:0] w_min [NumAxes];
    logic signed [COORD_WIDTH-1:0] w_max [NumAxes];

    // Configuration registers; indexes past the last are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_x_lo <= RstRowXLo;
            r_row_x_hi <= RstRowXHi;
            r_row_y_lo <= RstRowYLo;
            r_row_y_hi <= RstRowYHi;
            r_row_z_lo <= RstRowZLo;
            r_row_z_hi <= RstRowZHi;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegRowXLo: r_row_x_lo <= i_cfg_data;
                RegRowXHi: r_row_x_hi <= i_cfg_data;
                RegRowYLo: r_row_y_lo <= i_cfg_data;
                RegRowYHi: r_row_y_hi <= i_cfg_data;
                RegRowZLo: r_row_z_lo <= i_cfg_data;
                RegRowZHi: r_row_z_hi <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Unpack the two corners
    always_comb begin
        for (int j = 0; j < NumAxes; j++) begin
            w_lo[j] = i_s_tdata[j*COORD_WIDTH +: COORD_WIDTH];
            w_hi[j] = i_s_tdata[(j+NumAxes)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    aat_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .o_ctl       (w_ctl)
    );

    aat_row #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_row_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg_lo (r_row_x_lo),
        .i_cfg_hi (r_row_x_hi),
        .i_lo     (w_lo),
        .i_hi     (w_hi),
        .o_min    (w_min[0]),
        .o_max    (w_max[0])
    );

    aat_row #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_row_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg_lo (r_row_y_lo),
        .i_cfg_hi (r_row_y_hi),
        .i_lo     (w_lo),
        .i_hi     (w_hi),
        .o_min    (w_min[1]),
        .o_max    (w_max[1])
    );

    aat_row #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_row_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg_lo (r_row_z_lo),
        .i_cfg_hi (r_row_z_hi),
        .i_lo     (w_lo),
        .i_hi     (w_hi),
        .o_min    (w_min[2]),
        .o_max    (w_max[2])
    );

    // Handshake and result packing
    assign o_s_tready = w_ctl.en[0];
    assign o_m_tvalid = w_ctl.v[LastStage];
    assign o_m_tdata  = DW'({w_max[2], w_max[1], w_max[0], w_min[2], w_min[1], w_min[0]});

endmodule
`default_nettype wire

### dv/tb_aabb_affine_transform.sv
// Self-checking testbench for the bounding-box affine transform: directed table, then random.
`default_nettype none
module tb_aabb_affine_transform;
    timeunit 1ns;
    timeprecision 1ps;

    import aat_pkg::*;

    localparam int CoordW     = DefCoordWidth;
    localparam int FracW      = DefFracBits;
    localparam int DataW      = ((6 * CoordW + 7) / 8) * 8;
    localparam int CycleLimit = 200_000;
    localparam int RandPhases = 10;
    localparam int PhaseBoxes = 50;

    // Indexes past the last register: writes must leave the matrix alone
    localparam logic [CfgIdxWidth-1:0] RegSpare0 = 3'd6;
    localparam logic [CfgIdxWidth-1:0] RegSpare1 = 3'd7;

    localparam logic signed [CoordW-1:0] CoordMaxVal = 32'sh7FFF_FFFF;
    localparam logic signed [CoordW-1:0] CoordMinVal = 32'sh8000_0000;
    localparam logic [CoefWidth-1:0]     CoefMax     = 32'h7FFF_FFFF;
    localparam logic [CoefWidth-1:0]     CoefMin     = 32'h8000_0000;
    localparam logic [CoefWidth-1:0]     CoefOne     = 32'h0001_0000;
    localparam logic signed [127:0]      SatHi       = 128'sh7FFF_FFFF;
    localparam logic signed [127:0]      SatLo       = -SatHi - 1;

    // First member sits in the top bits, so min_x lands at bit 0 of tdata
    typedef struct packed {
        logic signed [CoordW-1:0] max_z;
        logic signed [CoordW-1:0] max_y;
        logic signed [CoordW-1:0] max_x;
        logic signed [CoordW-1:0] min_z;
        logic signed [CoordW-1:0] min_y;
        logic signed [CoordW-1:0] min_x;
    } t_box;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_BOX_TYPED,
        STEP_BOX_PRED
    } t_step_kind;

    typedef struct {
        t_step_kind             kind;
        logic [CfgIdxWidth-1:0] idx;
        logic [CfgWidth-1:0]    data;
        t_box                   box;
        t_box                   want;
    } t_step;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [DataW-1:0]       i_s_tdata;   // min_x, min_y, min_z, max_x, max_y, max_z
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [DataW-1:0]       o_m_tdata;   // min_x, min_y, min_z, max_x, max_y, max_z
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CfgIdxWidth-1:0] i_cfg_index;
    logic [CfgWidth-1:0]    i_cfg_data;

    logic [CfgWidth-1:0] matrix_reg [6];
    t_box                want_boxes [$];
    t_step               plan [$];
    int                  mismatch_count;
    int                  cycle_count;
    bit                  steady_flow;
    string               field_name [6] = '{"min_x", "min_y", "min_z", "max_x", "max_y", "max_z"};

    aabb_affine_transform dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Eight corners through the matrix, exact sum, floor, saturate, then min/max per axis
    function automatic t_box transform_box(t_box b);
        logic signed [CoordW-1:0] lo_c [3];
        logic signed [CoordW-1:0] hi_c [3];
        logic signed [CoordW-1:0] corner [3];
        logic signed [CoordW-1:0] mn [3];
        logic signed [CoordW-1:0] mx [3];
        logic signed [CoordW-1:0] v;
        logic signed [127:0]      acc;
        logic signed [127:0]      tw;
        logic [CfgWidth-1:0]      ra;
        logic [CfgWidth-1:0]      rb;
        t_box                     res;
        for (int a = 0; a < 3; a++) begin
            lo_c[a] = b[a*CoordW +: CoordW];
            hi_c[a] = b[(a+3)*CoordW +: CoordW];
        end
        for (int k = 0; k < 8; k++) begin
            for (int a = 0; a < 3; a++)
                corner[a] = k[a] ? hi_c[a] : lo_c[a];
            for (int r = 0; r < 3; r++) begin
                ra  = matrix_reg[2*r];
                rb  = matrix_reg[2*r+1];
                tw  = $signed(rb[31:0]);
                acc = $signed(ra[63:32]) * corner[0] + $signed(ra[31:0]) * corner[1]
                    + $signed(rb[63:32]) * corner[2] + (tw <<< FracW);
                acc = acc >>> FracW;
                if (acc > SatHi)
                    v = CoordMaxVal;
                else if (acc < SatLo)
                    v = CoordMinVal;
                else
                    v = acc[CoordW-1:0];
                if (k == 0 || v < mn[r]) mn[r] = v;
                if (k == 0 || v > mx[r]) mx[r] = v;
            end
        end
        for (int r = 0; r < 3; r++) begin
            res[r*CoordW +: CoordW]     = mn[r];
            res[(r+3)*CoordW +: CoordW] = mx[r];
        end
        return res;
    endfunction

    function automatic t_box mk_box(logic signed [CoordW-1:0] nx, logic signed [CoordW-1:0] ny,
                                    logic signed [CoordW-1:0] nz, logic signed [CoordW-1:0] xx,
                                    logic signed [CoordW-1:0] xy, logic signed [CoordW-1:0] xz);
        t_box b;
        b.min_x = nx; b.min_y = ny; b.min_z = nz;
        b.max_x = xx; b.max_y = xy; b.max_z = xz;
        return b;
    endfunction

    function automatic t_box same_box(logic signed [CoordW-1:0] v);
        return mk_box(v, v, v, v, v, v);
    endfunction

    function automatic void add_cfg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] data);
        t_step s;
        s.kind = STEP_CFG;
        s.idx  = idx;
        s.data = data;
        plan.push_back(s);
    endfunction

    function automatic void add_box(t_box b);
        t_step s;
        s.kind = STEP_BOX_PRED;
        s.box  = b;
        plan.push_back(s);
    endfunction

    function automatic void add_box_typed(t_box b, t_box want);
        t_step s;
        s.kind = STEP_BOX_TYPED;
        s.box  = b;
        s.want = want;
        plan.push_back(s);
    endfunction

    // Mostly small coefficients so results stay in range, with extremes and full-width noise
    function automatic logic [CoefWidth-1:0] rand_coef(bit is_shift);
        int unsigned span;
        span = is_shift ? 32'h0400_0000 : 32'h0004_0000;
        case ($urandom_range(0, 15))
            0:       return CoefMax;
            1:       return CoefMin;
            2, 3:    return $urandom;
            4:       return '0;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    // Well-formed boxes mostly; some inverted, some with fully random fields
    function automatic t_box rand_box();
        int unsigned              mode;
        int unsigned              span;
        logic signed [CoordW-1:0] p;
        logic signed [CoordW-1:0] q;
        t_box                     b;
        mode = $urandom_range(0, 9);
        span = $urandom_range(0, 1) ? 32'h0010_0000 : 32'h0400_0000;
        for (int a = 0; a < 3; a++) begin
            if (mode == 0) begin
                p = $urandom;
                q = $urandom;
            end else begin
                p = $urandom_range(0, 2 * span) - span;
                q = $urandom_range(0, 2 * span) - span;
            end
            if ((mode == 1) != (p > q)) begin
                b[a*CoordW +: CoordW]     = q;
                b[(a+3)*CoordW +: CoordW] = p;
            end else begin
                b[a*CoordW +: CoordW]     = p;
                b[(a+3)*CoordW +: CoordW] = q;
            end
        end
        return b;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer, tvalid left high
    task automatic send_box(t_box b, bit typed, t_box want);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        want_boxes.push_back(typed ? want : transform_box(b));
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] data, bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= RegRowZHi)
            matrix_reg[idx] = data;
        @(negedge i_clk);
        if (last)
            i_cfg_valid <= 1'b0;
    endtask

    // Stop sending and let every outstanding box come back before touching the matrix
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (want_boxes.size() != 0) @(negedge i_clk);
        repeat (PipeStages + 2) @(negedge i_clk);
    endtask

    // Result side: random stall before each transfer
    initial begin : result_sink
        int unsigned stall;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    // Compare each result transfer against the oldest outstanding box
    always @(posedge i_clk) begin : result_check
        t_box got;
        t_box want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata;
            if (want_boxes.size() == 0) begin
                $error("result with no box outstanding: %h", got);
                mismatch_count++;
            end else begin
                want = want_boxes.pop_front();
                for (int f = 0; f < 6; f++)
                    if (want[f*CoordW +: CoordW] !== got[f*CoordW +: CoordW]) begin
                        $error("%s: expected %h, actual %h", field_name[f],
                               want[f*CoordW +: CoordW], got[f*CoordW +: CoordW]);
                        mismatch_count++;
                    end
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        t_box                ordinary;
        t_box                extremes;
        t_box                inverted;
        logic [CfgWidth-1:0] m [6];

        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = RegRowXLo;
        i_cfg_data     = '0;
        mismatch_count = 0;
        steady_flow    = 1'b0;
        matrix_reg     = '{RstRowXLo, RstRowXHi, RstRowYLo, RstRowYHi, RstRowZLo, RstRowZHi};

        ordinary = mk_box(32'sh0001_8000, 32'shFFFD_C000, 32'sh0003_0000,
                          32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000);
        extremes = mk_box(CoordMinVal, CoordMinVal, CoordMinVal,
                          CoordMaxVal, CoordMaxVal, CoordMaxVal);
        inverted = mk_box(CoordMaxVal, CoordMaxVal, CoordMaxVal,
                          CoordMinVal, CoordMinVal, CoordMinVal);

        // Identity out of reset: boxes come back unchanged, inverted ones reordered
        add_box_typed(same_box('0), same_box('0));
        add_box_typed(extremes, extremes);
        add_box_typed(inverted, extremes);
        add_box_typed(ordinary, ordinary);
        // Writes past the last register index change nothing
        add_cfg(RegSpare0, '1);
        add_cfg(RegSpare1, '1);
        add_box_typed(ordinary, ordinary);

        // Largest positive coefficients everywhere: saturation both ways
        add_cfg(RegRowXLo, {CoefMax, CoefMax});
        add_cfg(RegRowXHi, {CoefMax, CoefMax});
        add_cfg(RegRowYLo, {CoefMax, CoefMax});
        add_cfg(RegRowYHi, {CoefMax, CoefMax});
        add_cfg(RegRowZLo, {CoefMax, CoefMax});
        add_cfg(RegRowZHi, {CoefMax, CoefMax});
        add_box_typed(same_box(CoordMaxVal), same_box(CoordMaxVal));
        add_box_typed(same_box(CoordMinVal), same_box(CoordMinVal));
        add_box_typed(same_box('0), same_box(CoordMaxVal));
        add_box(extremes);

        // Most negative coefficients everywhere
        add_cfg(RegRowXLo, {CoefMin, CoefMin});
        add_cfg(RegRowXHi, {CoefMin, CoefMin});
        add_cfg(RegRowYLo, {CoefMin, CoefMin});
        add_cfg(RegRowYHi, {CoefMin, CoefMin});
        add_cfg(RegRowZLo, {CoefMin, CoefMin});
        add_cfg(RegRowZHi, {CoefMin, CoefMin});
        add_box_typed(same_box(CoordMinVal), same_box(CoordMaxVal));
        add_box_typed(same_box(CoordMaxVal), same_box(CoordMinVal));
        add_box_typed(same_box('0), same_box(CoordMinVal));
        add_box(mk_box(32'sh0000_0001, CoordMinVal, 32'shFFFF_FFFF,
                       CoordMaxVal, 32'sh0000_0000, 32'sh1234_5678));

        // Half-LSB products: truncation must round towards minus infinity
        add_cfg(RegRowXLo, {32'h0000_8000, 32'h0000_0000});
        add_cfg(RegRowXHi, '0);
        add_cfg(RegRowYLo, {32'h0000_0000, 32'hFFFF_8000});
        add_cfg(RegRowYHi, '0);
        add_cfg(RegRowZLo, '0);
        add_cfg(RegRowZHi, {CoefOne, 32'hFFFF_FFFF});
        add_box(mk_box(32'sd1, 32'sd1, 32'sd0, 32'sd3, -32'sd1, 32'sd5));
        add_box(mk_box(-32'sd1, -32'sd3, -32'sd7, -32'sd1, 32'sd2, 32'sd9));
        add_box(extremes);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int n = 0; n < plan.size(); n++) begin
            if (plan[n].kind == STEP_CFG) begin
                if (n == 0 || plan[n-1].kind != STEP_CFG)
                    wait_idle();
                write_reg(plan[n].idx, plan[n].data,
                          n + 1 == plan.size() || plan[n+1].kind != STEP_CFG);
            end else begin
                send_box(plan[n].box, plan[n].kind == STEP_BOX_TYPED, plan[n].want);
            end
        end

        // Random matrices, random boxes; some phases run without any idling
        for (int p = 0; p < RandPhases; p++) begin
            wait_idle();
            steady_flow = (p % 3 == 2);
            for (int r = 0; r < 6; r++)
                m[r] = {rand_coef(1'b0), rand_coef(r % 2 == 1)};
            for (int r = 0; r < 6; r++)
                write_reg(r[CfgIdxWidth-1:0], m[r], r == 5);
            for (int i = 0; i < PhaseBoxes; i++)
                send_box(rand_box(), 1'b0, ordinary);
        end

        steady_flow = 1'b0;
        i_s_tvalid <= 1'b0;
        while (want_boxes.size() != 0) @(negedge i_clk);
        repeat (PipeStages * 4) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

### files.f
src/aat_pkg.sv
src/aat_pipe_ctrl.sv
src/aat_row.sv
src/aabb_affine_transform.sv
dv/tb_aabb_affine_transform.sv
